[src/rsi_pkg.sv]
// Package for the RSI threshold trader: configuration record, register
// indexes, action codes and the fixed field widths of the result beat.
// No dependencies.
package rsi_pkg;

  localparam int WINDOW_MAX_DEF = 32;
  localparam int PRICE_BITS_DEF = 24;
  localparam int QUEUE_DEPTH    = 2;

  localparam int WIN_LEN_W = 6;
  localparam int LEVEL_W   = 14;
  localparam int LIMIT_W   = 8;
  localparam int HELD_W    = 9;
  localparam int CASH_W    = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 14;

  // Full-scale RSI in hundredths of a percent.
  localparam int RSI_FULL = 10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN       = 2'd0,
    CFG_OVERSOLD_LEVEL   = 2'd1,
    CFG_OVERBOUGHT_LEVEL = 2'd2,
    CFG_POSITION_LIMIT   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_e;

  typedef struct packed {
    logic [WIN_LEN_W-1:0] window_len;
    logic [LEVEL_W-1:0]   oversold_level;
    logic [LEVEL_W-1:0]   overbought_level;
    logic [LIMIT_W-1:0]   position_limit;
  } cfg_t;

endpackage

[src/rsi_if.sv]
// Valid/ready channel interfaces for the price input and the trade result.
// Depends on nothing; widths of the result beat are fixed.
interface rsi_in_if #(
  parameter int PRICE_BITS = 24
) ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] close_price;

  modport source (output valid, output close_price, input ready);
  modport sink   (input valid, input close_price, output ready);
endinterface

interface rsi_out_if ();
  logic               valid;
  logic               ready;
  logic               signal_ready;
  logic [1:0]         action;
  logic signed [8:0]  held_units;
  logic signed [47:0] cash_balance;
  logic signed [47:0] net_value;

  modport source (output valid, output signal_ready, output action, output held_units,
                  output cash_balance, output net_value, input ready);
  modport sink   (input valid, input signal_ready, input action, input held_units,
                  input cash_balance, input net_value, output ready);
endinterface

[src/rsi_threshold_trade_signal.sv]
// RSI threshold trader, top level. Takes one beat per cycle while the queue has
// room; a price beat passes through the queue, the compare stage, the trade stage
// and the mark-to-market stage, and results leave one a cycle while the sink is
// ready. Reset clears control, sums, position and cash and loads the default
// configuration; the move ring is not cleared and needs no clearing pass.
// Depends on rsi_pkg and the channel interfaces in rsi_if.
module rsi_threshold_trade_signal
  import rsi_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rsi_in_if.sink               price_i,
  rsi_out_if.source            result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  // Each queue entry carries the window-full flag, both sums and the price
  // of the day, so the back end can trade on the price whose window ends
  // on that day.
  localparam int SUM_W  = PRICE_BITS + $clog2(WINDOW_MAX);
  localparam int DATA_W = 1 + 2 * SUM_W + PRICE_BITS;

  cfg_t                  cfg_q;
  logic                  win_clr, accept, q_full, q_valid, q_pop, full_win;
  logic [SUM_W-1:0]      gain, loss;
  logic [DATA_W-1:0]     push_data, head_data;

  // Writing the window length restarts the window; price, position and
  // cash are kept.
  assign win_clr = cfg_we_i && (cfg_idx_i == CFG_WINDOW_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len       <= WIN_LEN_W'(14);
      cfg_q.oversold_level   <= LEVEL_W'(3000);
      cfg_q.overbought_level <= LEVEL_W'(7000);
      cfg_q.position_limit   <= LIMIT_W'(5);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WINDOW_LEN:       cfg_q.window_len       <= cfg_data_i[WIN_LEN_W-1:0];
        CFG_OVERSOLD_LEVEL:   cfg_q.oversold_level   <= cfg_data_i[LEVEL_W-1:0];
        CFG_OVERBOUGHT_LEVEL: cfg_q.overbought_level <= cfg_data_i[LEVEL_W-1:0];
        CFG_POSITION_LIMIT:   cfg_q.position_limit   <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // The front end takes a beat whenever the queue has room, independent of
  // whether the result side is stalled.
  assign price_i.ready = !q_full;
  assign accept        = price_i.valid && !q_full;

  rsi_front #(
    .WINDOW_MAX (WINDOW_MAX),
    .PRICE_BITS (PRICE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .window_len_i (cfg_q.window_len),
    .win_clr_i    (win_clr),
    .accept_i     (accept),
    .price_i      (price_i.close_price),
    .full_win_o   (full_win),
    .gain_o       (gain),
    .loss_o       (loss)
  );

  assign push_data = {full_win, gain, loss, price_i.close_price};

  rsi_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (head_data)
  );

  // The back end holds the position and cash; a stalled result sink holds its
  // whole pipeline, which backs up into the queue and then the price channel.
  rsi_back #(
    .WINDOW_MAX (WINDOW_MAX),
    .PRICE_BITS (PRICE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (q_valid),
    .head_full_i  (head_data[DATA_W-1]),
    .head_gain_i  (head_data[DATA_W-2 -: SUM_W]),
    .head_loss_i  (head_data[PRICE_BITS+SUM_W-1 -: SUM_W]),
    .head_price_i (head_data[PRICE_BITS-1:0]),
    .pop_o        (q_pop),
    .result_o     (result_o)
  );

endmodule

[src/rsi_front.sv]
// Front end of the RSI trader: forms the daily move, keeps the move ring and
// the running gain and loss sums. Depends on rsi_pkg.
module rsi_front
  import rsi_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [WIN_LEN_W-1:0]  window_len_i,
  input  logic                  win_clr_i,
  input  logic                  accept_i,
  input  logic [PRICE_BITS-1:0] price_i,
  output logic                  full_win_o,
  output logic [PRICE_BITS+$clog2(WINDOW_MAX)-1:0] gain_o,
  output logic [PRICE_BITS+$clog2(WINDOW_MAX)-1:0] loss_o
);

  localparam int SLOT_W = $clog2(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int MOVE_W = PRICE_BITS + 1;
  localparam int SUM_W  = PRICE_BITS + SLOT_W;

  logic [PRICE_BITS-1:0]    last_q;
  logic                     have_q;
  logic [SLOT_W-1:0]        slot_q, slot_next, rd_addr;
  logic [CNT_W-1:0]         moves_q, moves_d, n_eff, slot_inc;
  logic [SUM_W-1:0]         gain_q, gain_d, loss_q, loss_d;
  logic signed [MOVE_W-1:0] move, move_neg, old_move, old_neg;
  logic [MOVE_W-1:0]        rd_q;
  logic [MOVE_W-1:0]        ring_mem [WINDOW_MAX];
  logic [PRICE_BITS-1:0]    mv_gain, mv_loss, old_gain, old_loss;
  logic                     advance, was_full;

  // A zero length acts as one move, a length past the ring acts as the ring.
  always_comb begin
    if (window_len_i == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(window_len_i) > WINDOW_MAX) begin
      n_eff = CNT_W'(WINDOW_MAX);
    end else begin
      n_eff = CNT_W'(window_len_i);
    end
  end

  assign advance   = accept_i && have_q;
  assign slot_inc  = CNT_W'(slot_q) + CNT_W'(1);
  assign slot_next = (slot_inc >= n_eff) ? '0 : slot_inc[SLOT_W-1:0];

  assign move     = $signed({1'b0, price_i}) - $signed({1'b0, last_q});
  assign move_neg = -move;
  assign mv_gain  = (move > 0) ? move[PRICE_BITS-1:0] : '0;
  assign mv_loss  = (move > 0) ? '0 : move_neg[PRICE_BITS-1:0];

  assign old_move = $signed(rd_q);
  assign old_neg  = -old_move;
  assign old_gain = (old_move > 0) ? old_move[PRICE_BITS-1:0] : '0;
  assign old_loss = (old_move > 0) ? '0 : old_neg[PRICE_BITS-1:0];

  assign was_full = moves_q >= n_eff;

  always_comb begin
    gain_d  = gain_q + SUM_W'(mv_gain);
    loss_d  = loss_q + SUM_W'(mv_loss);
    moves_d = moves_q;
    if (was_full) begin
      gain_d = gain_d - SUM_W'(old_gain);
      loss_d = loss_d - SUM_W'(old_loss);
    end else begin
      moves_d = moves_q + CNT_W'(1);
    end
  end

  assign full_win_o = have_q && (moves_d >= n_eff);
  assign gain_o     = gain_d;
  assign loss_o     = loss_d;

  // The entry due to leave the window is fetched one beat ahead.
  always_comb begin
    if (win_clr_i) begin
      rd_addr = '0;
    end else if (advance) begin
      rd_addr = slot_next;
    end else begin
      rd_addr = slot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && !win_clr_i) begin
      ring_mem[slot_q] <= move;
    end
    if (advance && !win_clr_i && slot_next == slot_q) begin
      rd_q <= move;
    end else begin
      rd_q <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      have_q  <= 1'b0;
      slot_q  <= '0;
      moves_q <= '0;
      gain_q  <= '0;
      loss_q  <= '0;
    end else begin
      if (win_clr_i) begin
        slot_q  <= '0;
        moves_q <= '0;
        gain_q  <= '0;
        loss_q  <= '0;
      end else if (advance) begin
        slot_q  <= slot_next;
        moves_q <= moves_d;
        gain_q  <= gain_d;
        loss_q  <= loss_d;
      end
      if (accept_i) begin
        last_q <= price_i;
        have_q <= 1'b1;
      end
    end
  end

endmodule

[src/rsi_queue.sv]
// Small show-ahead FIFO that decouples the front end from the trade back end.
// Depends on nothing.
module rsi_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

[src/rsi_back.sv]
// Back end of the RSI trader: threshold compare, position and cash update,
// and mark-to-market value in a three-stage stalling pipeline. Uses rsi_pkg.
module rsi_back
  import rsi_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  head_valid_i,
  input  logic                  head_full_i,
  input  logic [PRICE_BITS+$clog2(WINDOW_MAX)-1:0] head_gain_i,
  input  logic [PRICE_BITS+$clog2(WINDOW_MAX)-1:0] head_loss_i,
  input  logic [PRICE_BITS-1:0] head_price_i,
  output logic                  pop_o,
  rsi_out_if.source             result_o
);

  localparam int SUM_W  = PRICE_BITS + $clog2(WINDOW_MAX);
  localparam int PROD_W = SUM_W + LEVEL_W + 1;
  localparam int MUL_W  = PRICE_BITS + HELD_W + 1;
  localparam int VAL_W  = ((MUL_W > CASH_W) ? MUL_W : CASH_W) + 1;
  localparam logic signed [VAL_W-1:0] VMAX = VAL_W'({1'b0, {(CASH_W-1){1'b1}}});
  localparam logic signed [VAL_W-1:0] VMIN = -VMAX - VAL_W'(1);
  localparam logic signed [CASH_W:0]  CMAX = {2'b00, {(CASH_W-1){1'b1}}};
  localparam logic signed [CASH_W:0]  CMIN = -CMAX - (CASH_W+1)'(1);

  logic                     adv;
  logic [PROD_W-1:0]        num, den, os_den, ob_den;
  logic                     le_os, ge_ob, eq_ob, blocked;
  logic                     v1_q, full1_q, buy1_q, sell1_q;
  logic [PRICE_BITS-1:0]    price1_q, price2_q;
  logic                     v2_q, full2_q;
  action_e                  act2_q, act_d;
  logic signed [HELD_W-1:0] pos_q, pos_d;
  logic signed [CASH_W-1:0] cash_q, cash_d;
  logic signed [CASH_W:0]   cash_sum;
  logic signed [HELD_W:0]   pos_w, lim_w;
  logic signed [MUL_W-1:0]  mark;
  logic signed [VAL_W-1:0]  val_sum, val_sat;
  logic                     ov_q, out_full_q;
  action_e                  out_act_q;
  logic signed [HELD_W-1:0] out_pos_q;
  logic signed [CASH_W-1:0] out_cash_q, out_val_q;

  assign adv   = !ov_q || result_o.ready;
  assign pop_o = adv && head_valid_i;

  // RSI compare by cross-multiplication; with no losses RSI is full scale.
  assign num    = PROD_W'(head_gain_i) * PROD_W'(RSI_FULL);
  assign den    = PROD_W'(head_gain_i) + PROD_W'(head_loss_i);
  assign os_den = PROD_W'(cfg_i.oversold_level) * den;
  assign ob_den = PROD_W'(cfg_i.overbought_level) * den;

  always_comb begin
    if (head_loss_i == '0) begin
      le_os = 32'(RSI_FULL) <= 32'(cfg_i.oversold_level);
      ge_ob = 32'(RSI_FULL) >= 32'(cfg_i.overbought_level);
      eq_ob = 32'(RSI_FULL) == 32'(cfg_i.overbought_level);
    end else begin
      le_os = num <= os_den;
      ge_ob = num >= ob_den;
      eq_ob = num == ob_den;
    end
  end

  // Equal thresholds hit exactly give no trade.
  assign blocked = (cfg_i.oversold_level == cfg_i.overbought_level) && eq_ob;

  assign pos_w = {pos_q[HELD_W-1], pos_q};
  assign lim_w = $signed({2'b00, cfg_i.position_limit});

  always_comb begin
    pos_d    = pos_q;
    cash_d   = cash_q;
    act_d    = ACT_NONE;
    cash_sum = {cash_q[CASH_W-1], cash_q};
    if (buy1_q && pos_w < lim_w) begin
      cash_sum = {cash_q[CASH_W-1], cash_q} - $signed((CASH_W+1)'(price1_q));
      pos_d    = pos_q + HELD_W'(1);
      act_d    = ACT_BUY;
    end else if (sell1_q && pos_w > -lim_w) begin
      cash_sum = {cash_q[CASH_W-1], cash_q} + $signed((CASH_W+1)'(price1_q));
      pos_d    = pos_q - HELD_W'(1);
      act_d    = ACT_SELL;
    end
    if (cash_sum > CMAX) begin
      cash_d = CMAX[CASH_W-1:0];
    end else if (cash_sum < CMIN) begin
      cash_d = CMIN[CASH_W-1:0];
    end else begin
      cash_d = cash_sum[CASH_W-1:0];
    end
  end

  // Mark to market with the position left by this beat's trade.
  assign mark    = MUL_W'(pos_q) * $signed({{(MUL_W-PRICE_BITS){1'b0}}, price2_q});
  assign val_sum = VAL_W'(cash_q) + VAL_W'(mark);

  always_comb begin
    if (val_sum > VMAX) begin
      val_sat = VMAX;
    end else if (val_sum < VMIN) begin
      val_sat = VMIN;
    end else begin
      val_sat = val_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      full1_q    <= 1'b0;
      buy1_q     <= 1'b0;
      sell1_q    <= 1'b0;
      price1_q   <= '0;
      v2_q       <= 1'b0;
      full2_q    <= 1'b0;
      act2_q     <= ACT_NONE;
      price2_q   <= '0;
      pos_q      <= '0;
      cash_q     <= '0;
      ov_q       <= 1'b0;
      out_full_q <= 1'b0;
      out_act_q  <= ACT_NONE;
      out_pos_q  <= '0;
      out_cash_q <= '0;
      out_val_q  <= '0;
    end else if (adv) begin
      v1_q     <= head_valid_i;
      full1_q  <= head_full_i;
      buy1_q   <= head_valid_i && head_full_i && !blocked && le_os;
      sell1_q  <= head_valid_i && head_full_i && !blocked && ge_ob;
      price1_q <= head_price_i;

      v2_q <= v1_q;
      if (v1_q) begin
        full2_q  <= full1_q;
        act2_q   <= act_d;
        price2_q <= price1_q;
        pos_q    <= pos_d;
        cash_q   <= cash_d;
      end

      ov_q <= v2_q;
      if (v2_q) begin
        out_full_q <= full2_q;
        out_act_q  <= act2_q;
        out_pos_q  <= pos_q;
        out_cash_q <= cash_q;
        out_val_q  <= val_sat[CASH_W-1:0];
      end
    end
  end

  assign result_o.valid        = ov_q;
  assign result_o.signal_ready = out_full_q;
  assign result_o.action       = out_act_q;
  assign result_o.held_units   = out_pos_q;
  assign result_o.cash_balance = out_cash_q;
  assign result_o.net_value    = out_val_q;

endmodule

[dv/rsi_trade_checker.sv]
// Checker for the RSI threshold trader: watches the price and result channels
// and the register write port, predicts every result beat and compares it.
// Depends on rsi_pkg and the channel interfaces in rsi_if.
module rsi_trade_checker
  import rsi_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rsi_in_if                    price_mon,
  rsi_out_if                   result_mon,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output int                   pending_o,
  output int                   fail_count_o,
  output int                   days_o,
  output int                   buys_o,
  output int                   sells_o,
  output int                   full_days_o
);

  localparam longint CASH_MAX = (longint'(1) <<< (CASH_W - 1)) - 1;
  localparam longint CASH_MIN = -CASH_MAX - 1;

  typedef struct {
    logic               signal_ready;
    action_e            action;
    logic signed [8:0]  held_units;
    logic signed [47:0] cash_balance;
    logic signed [47:0] net_value;
  } day_result_t;

  cfg_t                      cfg_q;
  logic [PRICE_BITS_DEF-1:0] last_close;
  bit                        have_close;
  longint                    move_hist [WINDOW_MAX_DEF];
  int unsigned               hist_slot;
  int unsigned               moves_known;
  longint unsigned           gain_total;
  longint unsigned           loss_total;
  int                        units_held;
  longint                    cash_held;

  day_result_t outstanding_q [$];
  int          mismatches;
  int          days_seen;
  int          buy_count;
  int          sell_count;
  int          full_count;

  function automatic longint clamp_cash(input longint v);
    if (v > CASH_MAX) return CASH_MAX;
    if (v < CASH_MIN) return CASH_MIN;
    return v;
  endfunction

  function automatic void restart_window();
    hist_slot   = 0;
    moves_known = 0;
    gain_total  = 0;
    loss_total  = 0;
  endfunction

  // One trading day: update the move window, decide the trade, mark to market.
  function automatic day_result_t trade_day(input logic [PRICE_BITS_DEF-1:0] close);
    day_result_t     r;
    int unsigned     n;
    int unsigned     slot;
    longint          mv;
    longint          old;
    longint          value;
    longint unsigned num;
    longint unsigned den;
    longint unsigned os;
    longint unsigned ob;
    bit              le_os;
    bit              ge_ob;
    bit              eq_ob;
    int              lim;

    if (cfg_q.window_len == 0) n = 1;
    else if (cfg_q.window_len > WINDOW_MAX_DEF) n = WINDOW_MAX_DEF;
    else n = 32'(cfg_q.window_len);

    r.signal_ready = 1'b0;
    r.action       = ACT_NONE;

    if (have_close) begin
      mv   = longint'(close) - longint'(last_close);
      slot = (hist_slot < WINDOW_MAX_DEF) ? hist_slot : 0;
      if (moves_known >= n) begin
        old = move_hist[slot];
        if (old > 0) gain_total -= old;
        else loss_total -= -old;
      end
      move_hist[slot] = mv;
      if (mv > 0) gain_total += mv;
      else loss_total += -mv;
      hist_slot = (slot + 1 >= n) ? 0 : slot + 1;
      if (moves_known < n) moves_known++;

      if (moves_known >= n) begin
        r.signal_ready = 1'b1;
        os = 64'(cfg_q.oversold_level);
        ob = 64'(cfg_q.overbought_level);
        if (loss_total == 0) begin
          le_os = RSI_FULL <= os;
          ge_ob = RSI_FULL >= ob;
          eq_ob = RSI_FULL == ob;
        end else begin
          num   = longint'(RSI_FULL) * gain_total;
          den   = gain_total + loss_total;
          le_os = num <= os * den;
          ge_ob = num >= ob * den;
          eq_ob = num == ob * den;
        end
        // RSI sitting exactly on two equal thresholds is a dead band.
        if (!(os == ob && eq_ob)) begin
          lim = int'(cfg_q.position_limit);
          if (le_os && units_held < lim) begin
            cash_held = clamp_cash(cash_held - longint'(close));
            units_held++;
            r.action = ACT_BUY;
          end else if (ge_ob && units_held > -lim) begin
            cash_held = clamp_cash(cash_held + longint'(close));
            units_held--;
            r.action = ACT_SELL;
          end
        end
      end
    end

    last_close = close;
    have_close = 1'b1;
    value      = clamp_cash(cash_held + longint'(units_held) * longint'(close));

    r.held_units   = units_held[8:0];
    r.cash_balance = cash_held[47:0];
    r.net_value    = value[47:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    day_result_t want;
    if (!rst_ni) begin
      cfg_q.window_len       = WIN_LEN_W'(14);
      cfg_q.oversold_level   = LEVEL_W'(3000);
      cfg_q.overbought_level = LEVEL_W'(7000);
      cfg_q.position_limit   = LIMIT_W'(5);
      last_close  = '0;
      have_close  = 1'b0;
      restart_window();
      units_held  = 0;
      cash_held   = 0;
      outstanding_q.delete();
      mismatches  = 0;
      days_seen   = 0;
      buy_count   = 0;
      sell_count  = 0;
      full_count  = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
      days_o       <= 0;
      buys_o       <= 0;
      sells_o      <= 0;
      full_days_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WINDOW_LEN: begin
            cfg_q.window_len = cfg_data_i[WIN_LEN_W-1:0];
            restart_window();
          end
          CFG_OVERSOLD_LEVEL:   cfg_q.oversold_level   = cfg_data_i[LEVEL_W-1:0];
          CFG_OVERBOUGHT_LEVEL: cfg_q.overbought_level = cfg_data_i[LEVEL_W-1:0];
          CFG_POSITION_LIMIT:   cfg_q.position_limit   = cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end

      // A result always leaves after its price has been accepted, so the result
      // side is settled before this edge's price is predicted.
      if (result_mon.valid && result_mon.ready) begin
        if (outstanding_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result beat with no price waiting: ready %0b action %0d ",
                     $time, result_mon.signal_ready, result_mon.action,
                     "held %0d cash %0d value %0d", result_mon.held_units,
                     result_mon.cash_balance, result_mon.net_value);
        end else begin
          want = outstanding_q.pop_front();
          if (result_mon.signal_ready !== want.signal_ready ||
              result_mon.action       !== want.action       ||
              result_mon.held_units   !== want.held_units   ||
              result_mon.cash_balance !== want.cash_balance ||
              result_mon.net_value    !== want.net_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] day %0d mismatch: expected ready %0b action %0d held %0d ",
                       $time, days_seen, want.signal_ready, want.action, want.held_units,
                       "cash %0d value %0d; got ready %0b action %0d held %0d ",
                       want.cash_balance, want.net_value, result_mon.signal_ready,
                       result_mon.action, result_mon.held_units,
                       "cash %0d value %0d", result_mon.cash_balance,
                       result_mon.net_value);
          end
        end
      end

      if (price_mon.valid && price_mon.ready) begin
        want = trade_day(price_mon.close_price);
        outstanding_q.insert(outstanding_q.size(), want);
        days_seen++;
        if (want.signal_ready) full_count++;
        if (want.action == ACT_BUY) buy_count++;
        if (want.action == ACT_SELL) sell_count++;
      end

      pending_o    <= outstanding_q.size();
      fail_count_o <= mismatches;
      days_o       <= days_seen;
      buys_o       <= buy_count;
      sells_o      <= sell_count;
      full_days_o  <= full_count;
    end
  end

endmodule

[dv/rsi_threshold_trade_signal_tb.sv]
// Testbench top for the RSI threshold trader: clock, reset, price stimulus,
// result back-pressure, register writes and the final verdict.
// Depends on rsi_pkg, rsi_if, the block itself and rsi_trade_checker.
module rsi_threshold_trade_signal_tb;
  import rsi_pkg::*;

  // Longest deliberate hold-off of the result side, in cycles.
  localparam int HOLD_CYCLES = 120;
  // Cycles without any accepted beat before the run is declared hung. The
  // slowest correct stretch is the hold-off above and the restart after it.
  localparam int STALL_LIMIT = 2000;
  // Quiet time after the last drain, in which any stray beat can show itself.
  localparam int TAIL_CYCLES = 8;
  localparam int PHASES      = 7;
  localparam int PHASE_DAYS  = 100;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_data;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  bit hold_seen;
  int hold_left;
  int quiet_cycles = 0;
  int reg_writes   = 0;

  int pending;
  int fails;
  int days;
  int buys;
  int sells;
  int full_days;

  rsi_in_if #(.PRICE_BITS(PRICE_BITS_DEF)) price_if ();
  rsi_out_if result_if ();

  rsi_threshold_trade_signal u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .price_i    (price_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  rsi_trade_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .price_mon    (price_if),
    .result_mon   (result_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fails),
    .days_o       (days),
    .buys_o       (buys),
    .sells_o      (sells),
    .full_days_o  (full_days)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side. Normally ready is drawn afresh each cycle against the
  // current stall rate. When the stimulus flips hold_req, ready is held low
  // for a long stretch so that the block's queue fills and it must push
  // back on the price channel.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      result_if.ready <= 1'b0;
      hold_left       <= 0;
      hold_seen       <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen       <= hold_req;
      hold_left       <= HOLD_CYCLES;
      result_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any accepted beat on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (price_if.valid && price_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("No beat moved for %0d cycles, %0d results still outstanding.",
               STALL_LIMIT, pending);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one closing price, possibly after a random gap, and returns at the
  // edge where the beat is taken. Valid is left high so that back-to-back
  // beats need no gap between them.
  task automatic send_price(input logic [PRICE_BITS_DEF-1:0] close);
    while ($urandom_range(99) < send_idle_pct) begin
      price_if.valid <= 1'b0;
      @(posedge clk);
    end
    price_if.valid       <= 1'b1;
    price_if.close_price <= close;
    do @(posedge clk); while (!(price_if.valid && price_if.ready));
  endtask

  // Stops offering prices and waits until every predicted result has been
  // taken, so that the block is idle for a register write. The first edge is
  // always waited for, as the outstanding count is registered and lags acceptance.
  task automatic wait_drained();
    price_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // A single register write. The enable drops on the following edge and the task
  // returns only once it is low, so back-to-back writes never drive the enable
  // twice in the same time step.
  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DAT_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  initial begin
    int                        phase;
    int                        k;
    int                        roll;
    int                        amp;
    int                        drift;
    int                        walk;
    int unsigned               win;
    int unsigned               os;
    int unsigned               ob;
    int unsigned               lim;
    logic [PRICE_BITS_DEF-1:0] close;

    price_if.valid       = 1'b0;
    price_if.close_price = '0;
    cfg_we               = 1'b0;
    cfg_idx              = CFG_WINDOW_LEN;
    cfg_data             = '0;
    hold_req             = 1'b0;
    send_idle_pct        = 28;
    recv_stall_pct       = 45;
    rst_n                = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---------------------------------------------------------------------
    // Directed days.
    // ---------------------------------------------------------------------
    // The very first price forms no move; the second is a full-scale rise
    // from zero, still far short of the default fourteen-move window.
    send_price('0);
    send_price('1);
    wait_drained();

    // A window length of zero behaves as one, so every day is a full window.
    // Equal thresholds of 50 %: a fall gives RSI 0 and buys, a rise and a
    // flat day both give RSI 100 % (no losses) and sell.
    cfg_write(CFG_WINDOW_LEN, 0);
    cfg_write(CFG_OVERSOLD_LEVEL, 5000);
    cfg_write(CFG_OVERBOUGHT_LEVEL, 5000);
    cfg_write(CFG_POSITION_LIMIT, 2);
    send_price(100);
    send_price(200);
    send_price(200);
    wait_drained();

    // Two-move window. After a sell at RSI 88.88 %, equal gains and losses put
    // RSI exactly on both equal thresholds, which must not trade.
    cfg_write(CFG_WINDOW_LEN, 2);
    send_price(1000);
    send_price(900);
    send_price(1000);
    send_price(900);
    wait_drained();

    // Thresholds above full scale are compared as written: every day is
    // oversold, so buys run up to the limit and then stop.
    cfg_write(CFG_OVERSOLD_LEVEL, 16383);
    cfg_write(CFG_OVERBOUGHT_LEVEL, 16383);
    cfg_write(CFG_POSITION_LIMIT, 3);
    cfg_write(CFG_WINDOW_LEN, 1);
    send_price(900);
    send_price(5000);
    send_price('1);
    send_price('1);
    send_price(12345);
    send_price(12345);
    wait_drained();

    // Limit lowered below the held position: buys are refused, while sells
    // at a zero overbought level carry on down through zero to the short side.
    cfg_write(CFG_POSITION_LIMIT, 1);
    cfg_write(CFG_OVERBOUGHT_LEVEL, 0);
    send_price(12345);
    send_price('0);
    send_price('1);
    send_price('0);
    wait_drained();

    // An oversized window length acts as the largest window and does not
    // fill within a few days.
    cfg_write(CFG_WINDOW_LEN, 63);
    cfg_write(CFG_OVERSOLD_LEVEL, 0);
    cfg_write(CFG_OVERBOUGHT_LEVEL, 10000);
    send_price(777);
    send_price(16777000);
    send_price(3);
    wait_drained();

    // ---------------------------------------------------------------------
    // Random phases. Prices follow a random walk whose drift changes every
    // sixteen days, so RSI sweeps through its whole range and both kinds of
    // trade happen. A few days jump to a random, zero or full-scale price.
    // ---------------------------------------------------------------------
    walk = $urandom_range(2000000, 1000);
    for (phase = 0; phase < PHASES; phase++) begin
      // Idling pattern: sender light and receiver heavy, then the reverse,
      // then no idling at all.
      if (phase < 2) begin
        send_idle_pct  = 28;
        recv_stall_pct <= 45;
      end else if (phase < 4) begin
        send_idle_pct  = 45;
        recv_stall_pct <= 28;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
      end

      case (phase)
        0: begin
          win = $urandom_range(8, 2);
          os  = $urandom_range(4500, 2000);
          ob  = $urandom_range(8000, 5500);
          lim = $urandom_range(6, 1);
        end
        1: begin
          win = WINDOW_MAX_DEF;
          os  = $urandom_range(RSI_FULL);
          ob  = $urandom_range(RSI_FULL);
          lim = $urandom_range(20, 1);
        end
        2: begin
          win = 1;
          os  = 3000;
          ob  = 7000;
          lim = 3;
        end
        3: begin
          // Equal thresholds, so exact hits on the shared level are possible.
          win = $urandom_range(16, 3);
          os  = $urandom_range(7000, 3000);
          ob  = os;
          lim = 4;
        end
        4: begin
          win = $urandom_range(63, 33);
          os  = 4000;
          ob  = 6000;
          lim = 255;
        end
        5: begin
          // A zero limit only lets the position unwind towards flat.
          win = 2;
          os  = $urandom_range(RSI_FULL);
          ob  = $urandom_range(RSI_FULL);
          lim = 0;
        end
        default: begin
          win = $urandom_range(63);
          os  = $urandom_range(16383);
          ob  = $urandom_range(16383);
          lim = $urandom_range(255);
        end
      endcase

      cfg_write(CFG_WINDOW_LEN, CFG_DAT_W'(win));
      cfg_write(CFG_OVERSOLD_LEVEL, CFG_DAT_W'(os));
      cfg_write(CFG_OVERBOUGHT_LEVEL, CFG_DAT_W'(ob));
      cfg_write(CFG_POSITION_LIMIT, CFG_DAT_W'(lim));

      case ($urandom_range(3))
        0:       amp = 3;
        1:       amp = 40;
        2:       amp = 2000;
        default: amp = 300000;
      endcase

      for (k = 0; k < PHASE_DAYS; k++) begin
        if (k % 16 == 0) drift = int'($urandom_range(2 * amp)) - amp;
        // Long receiver hold-off half-way through two phases, while the
        // sender keeps offering prices.
        if (k == PHASE_DAYS / 2 && (phase == 3 || phase == 5)) hold_req <= ~hold_req;
        roll = $urandom_range(99);
        if (roll < 3) begin
          close = PRICE_BITS_DEF'($urandom_range(24'hFFFFFF));
        end else if (roll == 3) begin
          close = '0;
        end else if (roll == 4) begin
          close = '1;
        end else begin
          walk = walk + drift + int'($urandom_range(2 * amp)) - amp;
          if (walk < 0) walk = 0;
          if (walk > 24'hFFFFFF) walk = 24'hFFFFFF;
          close = walk[PRICE_BITS_DEF-1:0];
        end
        send_price(close);
      end
      wait_drained();
    end

    // Let any stray result beat show itself before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d trading days under %0d register writes;", days, reg_writes);
    $display("%0d days had a full window, with %0d buys and %0d sells.",
             full_days, buys, sells);
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d result beats disagreed, %0d still outstanding.", fails, pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/rsi_pkg.sv
src/rsi_if.sv
src/rsi_front.sv
src/rsi_queue.sv
src/rsi_back.sv
src/rsi_threshold_trade_signal.sv
dv/rsi_trade_checker.sv
dv/rsi_threshold_trade_signal_tb.sv
